FILE: design/mlcd_pkg.sv
// Shared codes and types for the memory LCD refresh core.
// No dependencies; the interfaces and the top level import this package.
`timescale 1ns / 1ps

package mlcd_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic [2:0] phase_t;
  typedef logic [1:0] reg_index_t;

  localparam kind_t KIND_DRAW  = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;
  localparam kind_t KIND_PULL  = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_BUSY  = 2'd2;

  localparam phase_t PH_IDLE      = 3'd0;
  localparam phase_t PH_KEEPALIVE = 3'd1;
  localparam phase_t PH_ADDR      = 3'd2;
  localparam phase_t PH_DATA      = 3'd3;
  localparam phase_t PH_TRAILER   = 3'd4;
  localparam phase_t PH_FINAL     = 3'd5;

  localparam reg_index_t REG_ROTATION      = 2'd0;
  localparam reg_index_t REG_WRITE_COMMAND = 2'd1;
  localparam reg_index_t REG_VCOM_MASK     = 2'd2;

endpackage

FILE: design/mlcd_in_if.sv
// Request channel of the memory LCD refresh core: valid, ready and payload.
// Depends on mlcd_pkg.
`timescale 1ns / 1ps

interface mlcd_in_if;
  import mlcd_pkg::*;

  logic               valid;
  logic               ready;
  kind_t              kind;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic               color;

  modport source (output valid, kind, x, y, color, input ready);
  modport sink   (input valid, kind, x, y, color, output ready);
endinterface

FILE: design/mlcd_out_if.sv
// Result channel of the memory LCD refresh core: valid, ready and payload.
// Depends on mlcd_pkg.
`timescale 1ns / 1ps

interface mlcd_out_if;
  import mlcd_pkg::*;

  logic       valid;
  logic       ready;
  logic       pixel;
  logic [7:0] spi_byte;
  logic       select_active;
  logic       frame_last;
  status_t    status;

  modport source (output valid, pixel, spi_byte, select_active, frame_last, status,
                  input ready);
  modport sink   (input valid, pixel, spi_byte, select_active, frame_last, status,
                  output ready);
endinterface

FILE: design/mlcd_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/memory_lcd_framebuffer_refresh_core.sv
// Top level of the memory LCD frame buffer and dirty-line refresh engine.
// Depends on mlcd_pkg, mlcd_in_if, mlcd_out_if and mlcd_ram.
//
// Usage: requests arrive on in_ch (draw, read, clear, pull next refresh byte),
// and each one yields exactly one result on out_ch. Registers (rotation,
// write command mask, VCOM mask) are to be written through
// cfg_we/cfg_index/cfg_data only while no request is in flight; the user
// must keep to this, as the core does not enforce it. The frame buffer and
// the line flags sit in two single-port RAMs with a registered read; draws
// are read-modify-write. A draw, a read or a data-byte pull passes through
// the execute, RAM read and data states before the response state; other
// pulls go from execute straight to response. A pull that searches for the
// next dirty line first primes the flag read and then examines the lines in
// turn. A clear refills both RAMs, one entry a cycle. One request is in
// flight at a time; in_ch.ready is high only while the core waits for work.
// Reset runs the same fill pass before the first request is taken.
// When out_ch stalls, the finished result holds in the output register and
// the core accepts the next request, holding its own result until the
// register frees up.
`timescale 1ns / 1ps

module memory_lcd_framebuffer_refresh_core #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  mlcd_in_if.sink               in_ch,
  mlcd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  mlcd_pkg::reg_index_t  cfg_index,
  input  logic [7:0]            cfg_data
);
  import mlcd_pkg::*;

  localparam int LINE_BYTES  = PANEL_WIDTH / 8;
  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int XW = $clog2(PANEL_WIDTH);
  localparam int LW = $clog2(PANEL_HEIGHT + 1);
  localparam int YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int PW = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
  localparam int BW = $clog2(LINE_BYTES + 1);

  localparam logic [2:0] C_SWEEP = 3'd0;
  localparam logic [2:0] C_IDLE  = 3'd1;
  localparam logic [2:0] C_EXEC  = 3'd2;
  localparam logic [2:0] C_READ  = 3'd3;
  localparam logic [2:0] C_DATA  = 3'd4;
  localparam logic [2:0] C_SCAN  = 3'd5;
  localparam logic [2:0] C_RESP  = 3'd6;

  logic [2:0]  ctrl;
  logic        sweep_reply;
  logic [AW-1:0] sweep_addr;

  logic [1:0]  rotation;
  logic [7:0]  write_command_mask;
  logic [7:0]  vcom_mask;

  logic [7:0]  dirty_total;
  logic        vcom_level;
  phase_t      frame_phase;
  logic [LW-1:0] current_line;
  logic [BW-1:0] byte_in_line;
  logic [LW-1:0] scan_line;
  logic [LW-1:0] probe_line;
  logic        probe_live;

  kind_t       req_kind;
  logic signed [15:0] req_x;
  logic signed [15:0] req_y;
  logic        req_color;

  logic [AW-1:0] addr_reg;
  logic [2:0]  bit_sel;
  logic [LW-1:0] draw_line;

  logic        res_pixel;
  logic [7:0]  res_byte;
  logic        res_sel;
  logic        res_last;
  status_t     res_status;

  logic        out_valid;
  logic        out_pixel;
  logic [7:0]  out_byte;
  logic        out_sel;
  logic        out_last;
  status_t     out_status;

  // Coordinate mapping from rotated space to buffer position.
  logic [15:0] lim_x;
  logic [15:0] lim_y;
  logic        in_range;
  logic [XW-1:0] map_bx;
  logic [LW-1:0] map_by;
  logic [PW-1:0] pix_index;
  logic [PW-1:0] line_index;
  logic [7:0]  vbyte;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [7:0]    bit_mask;

  logic          dirty_we;
  logic [YW-1:0] dirty_addr;
  logic          dirty_wdata;
  logic          dirty_rdata;

  always_comb begin
    lim_x = rotation[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
    lim_y = rotation[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
    in_range = !req_x[15] && !req_y[15] && (16'(req_x) < lim_x) && (16'(req_y) < lim_y);
    case (rotation)
      2'd1: begin
        map_bx = XW'(PANEL_WIDTH - 1) - XW'(req_y);
        map_by = LW'(req_x);
      end
      2'd2: begin
        map_bx = XW'(PANEL_WIDTH - 1) - XW'(req_x);
        map_by = LW'(PANEL_HEIGHT - 1) - LW'(req_y);
      end
      2'd3: begin
        map_bx = XW'(req_y);
        map_by = LW'(PANEL_HEIGHT - 1) - LW'(req_x);
      end
      default: begin
        map_bx = XW'(req_x);
        map_by = LW'(req_y);
      end
    endcase
    pix_index  = PW'(map_by) * PW'(PANEL_WIDTH) + PW'(map_bx);
    line_index = PW'(current_line) * PW'(LINE_BYTES) + PW'(byte_in_line);
    vbyte = vcom_level ? vcom_mask : 8'h00;
  end

  always_comb begin
    bit_mask  = 8'h01 << bit_sel;
    ram_we    = 1'b0;
    ram_addr  = addr_reg;
    ram_wdata = req_color ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    if (ctrl == C_SWEEP) begin
      ram_we    = 1'b1;
      ram_addr  = sweep_addr;
      ram_wdata = 8'hff;
    end else if (ctrl == C_DATA && req_kind == KIND_DRAW) begin
      ram_we = 1'b1;
    end
  end

  // The flag of the current line is read while idle, so it is ready when a
  // trailer pull executes.
  always_comb begin
    dirty_we    = 1'b0;
    dirty_addr  = current_line[YW-1:0];
    dirty_wdata = 1'b0;
    case (ctrl)
      C_SWEEP: begin
        dirty_addr  = sweep_addr[YW-1:0];
        dirty_wdata = 1'b1;
        dirty_we    = ({1'b0, sweep_addr} < (AW + 1)'(PANEL_HEIGHT));
      end
      C_EXEC: begin
        dirty_we = (req_kind == KIND_PULL) && (frame_phase == PH_TRAILER) && dirty_rdata;
      end
      C_READ: begin
        dirty_addr = draw_line[YW-1:0];
      end
      C_DATA: begin
        dirty_addr  = draw_line[YW-1:0];
        dirty_wdata = 1'b1;
        dirty_we    = (req_kind == KIND_DRAW) && !dirty_rdata;
      end
      C_SCAN: begin
        dirty_addr = scan_line[YW-1:0];
      end
      default: ;
    endcase
  end

  mlcd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  mlcd_ram #(
    .WIDTH (1),
    .DEPTH (PANEL_HEIGHT)
  ) u_line_dirty (
    .clk   (clk),
    .we    (dirty_we),
    .addr  (dirty_addr),
    .wdata (dirty_wdata),
    .rdata (dirty_rdata)
  );

  assign in_ch.ready          = (ctrl == C_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.pixel         = out_pixel;
  assign out_ch.spi_byte      = out_byte;
  assign out_ch.select_active = out_sel;
  assign out_ch.frame_last    = out_last;
  assign out_ch.status        = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation           <= 2'd0;
      write_command_mask <= 8'h01;
      vcom_mask          <= 8'h02;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION:      rotation           <= cfg_data[1:0];
        REG_WRITE_COMMAND: write_command_mask <= cfg_data;
        REG_VCOM_MASK:     vcom_mask          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl == C_RESP && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl == C_RESP && (!out_valid || out_ch.ready)) begin
      out_pixel  <= res_pixel;
      out_byte   <= res_byte;
      out_sel    <= res_sel;
      out_last   <= res_last;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_kind  <= in_ch.kind;
      req_x     <= in_ch.x;
      req_y     <= in_ch.y;
      req_color <= in_ch.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl         <= C_SWEEP;
      sweep_reply  <= 1'b0;
      sweep_addr   <= '0;
      dirty_total  <= 8'(PANEL_HEIGHT);
      vcom_level   <= 1'b1;
      frame_phase  <= PH_IDLE;
      current_line <= '0;
      byte_in_line <= '0;
      scan_line    <= '0;
      probe_live   <= 1'b0;
    end else begin
      case (ctrl)
        C_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(STORE_BYTES - 1)) begin
            sweep_addr <= '0;
            ctrl <= sweep_reply ? C_RESP : C_IDLE;
          end
        end
        C_IDLE: begin
          if (in_ch.valid) begin
            ctrl <= C_EXEC;
          end
        end
        C_EXEC: begin
          res_pixel  <= 1'b0;
          res_byte   <= 8'h00;
          res_sel    <= 1'b0;
          res_last   <= 1'b0;
          res_status <= ST_DONE;
          addr_reg   <= AW'(pix_index >> 3);
          bit_sel    <= map_bx[2:0];
          draw_line  <= map_by;
          probe_live <= 1'b0;
          ctrl       <= C_RESP;
          case (req_kind)
            KIND_DRAW, KIND_READ: begin
              if (req_kind == KIND_DRAW && frame_phase != PH_IDLE) begin
                res_status <= ST_BUSY;
              end else if (!in_range) begin
                res_status <= ST_RANGE;
              end else begin
                ctrl <= C_READ;
              end
            end
            KIND_CLEAR: begin
              if (frame_phase != PH_IDLE) begin
                res_status <= ST_BUSY;
              end else begin
                dirty_total <= 8'(PANEL_HEIGHT);
                sweep_reply <= 1'b1;
                ctrl        <= C_SWEEP;
              end
            end
            default: begin
              res_sel <= 1'b1;
              case (frame_phase)
                PH_IDLE: begin
                  vcom_level <= ~vcom_level;
                  if (dirty_total == 8'h00) begin
                    res_byte    <= vbyte;
                    frame_phase <= PH_KEEPALIVE;
                  end else begin
                    res_byte  <= vbyte | write_command_mask;
                    scan_line <= '0;
                    ctrl      <= C_SCAN;
                  end
                end
                PH_KEEPALIVE: begin
                  res_last    <= 1'b1;
                  frame_phase <= PH_IDLE;
                end
                PH_ADDR: begin
                  res_byte     <= 8'(current_line + LW'(1));
                  byte_in_line <= '0;
                  frame_phase  <= PH_DATA;
                end
                PH_DATA: begin
                  addr_reg <= AW'(line_index);
                  ctrl     <= C_READ;
                end
                PH_TRAILER: begin
                  if (dirty_rdata) begin
                    if (dirty_total != 8'h00) begin
                      dirty_total <= dirty_total - 8'h01;
                    end
                  end
                  scan_line <= current_line + LW'(1);
                  ctrl      <= C_SCAN;
                end
                default: begin
                  res_last     <= 1'b1;
                  dirty_total  <= 8'h00;
                  frame_phase  <= PH_IDLE;
                  current_line <= '0;
                  byte_in_line <= '0;
                end
              endcase
            end
          endcase
        end
        C_READ: begin
          ctrl <= C_DATA;
        end
        C_DATA: begin
          ctrl <= C_RESP;
          case (req_kind)
            KIND_DRAW: begin
              if (!dirty_rdata) begin
                dirty_total <= dirty_total + 8'h01;
              end
            end
            KIND_READ: begin
              res_pixel <= ram_rdata[bit_sel];
            end
            default: begin
              res_byte <= ram_rdata;
              if (byte_in_line + BW'(1) >= BW'(LINE_BYTES)) begin
                byte_in_line <= '0;
                frame_phase  <= PH_TRAILER;
              end else begin
                byte_in_line <= byte_in_line + BW'(1);
              end
            end
          endcase
        end
        C_SCAN: begin
          // A line flag arrives in the cycle after its read is issued, so each
          // cycle checks the line issued the cycle before and issues the next.
          if (probe_live && dirty_rdata) begin
            current_line <= probe_line;
            byte_in_line <= '0;
            frame_phase  <= PH_ADDR;
            ctrl         <= C_RESP;
          end else if (scan_line >= LW'(PANEL_HEIGHT)) begin
            current_line <= '0;
            byte_in_line <= '0;
            frame_phase  <= PH_FINAL;
            ctrl         <= C_RESP;
          end else begin
            probe_line <= scan_line;
            probe_live <= 1'b1;
            scan_line  <= scan_line + LW'(1);
          end
        end
        C_RESP: begin
          sweep_reply <= 1'b0;
          if (!out_valid || out_ch.ready) begin
            ctrl <= C_IDLE;
          end
        end
        default: begin
          ctrl <= C_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: tb/mlcd_tb_if.sv
// Testbench-side note: the channel interfaces come from the design folder.
// This file holds the request and result item types of the testbench; depends on mlcd_pkg.
`timescale 1ns / 1ps

package mlcd_tb_pkg;
  import mlcd_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               color;
  } lcd_request_t;

  typedef struct packed {
    logic       pixel;
    logic [7:0] spi_byte;
    logic       select_active;
    logic       frame_last;
    status_t    status;
  } lcd_result_t;
endpackage

FILE: tb/tb.sv
// Self-checking testbench for memory_lcd_framebuffer_refresh_core.
// Drives draw, read, clear and pull requests through the channel interfaces and
// checks every result against an internal model; depends on mlcd_pkg and mlcd_tb_pkg.
`timescale 1ns / 1ps

module tb;
  import mlcd_pkg::*;
  import mlcd_tb_pkg::*;

  localparam int W = 128;
  localparam int H = 128;
  localparam int LB = W / 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  reg_index_t cfg_index = REG_ROTATION;
  logic [7:0] cfg_data = 8'd0;

  mlcd_in_if  in_ch ();
  mlcd_out_if out_ch ();

  memory_lcd_framebuffer_refresh_core #(.PANEL_WIDTH(W), .PANEL_HEIGHT(H)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [W-1:0] m_pix [H];
  logic         m_dirty [H];
  int           m_dirty_total;
  logic         m_vcom;
  phase_t       m_phase;
  int           m_line;
  int           m_byte;
  logic [1:0]   m_rot;
  logic [7:0]   m_wcmd;
  logic [7:0]   m_vmask;

  lcd_request_t pending_requests[$];
  lcd_result_t  expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int pulls_seen = 0;
  int frames_seen = 0;

  function automatic bit map_xy(input logic signed [15:0] xi, input logic signed [15:0] yi,
                                output int bx, output int by);
    int x, y, w, h, t;
    x = xi;
    y = yi;
    w = m_rot[0] ? H : W;
    h = m_rot[0] ? W : H;
    if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
    case (m_rot)
      2'd1: begin t = x; x = W - 1 - y; y = t; end
      2'd2: begin x = W - 1 - x; y = H - 1 - y; end
      2'd3: begin t = x; x = y; y = H - 1 - t; end
      default: ;
    endcase
    bx = x;
    by = y;
    return 1'b1;
  endfunction

  function automatic void seek_line(input int from);
    int n;
    n = from;
    while (n < H && !m_dirty[n]) n++;
    if (n < H) begin
      m_line = n;
      m_phase = PH_ADDR;
    end else begin
      m_line = 0;
      m_phase = PH_FINAL;
    end
    m_byte = 0;
  endfunction

  function automatic lcd_result_t predict_result(input lcd_request_t r);
    lcd_result_t o;
    int bx, by;
    logic [7:0] vb;
    o = '0;
    case (r.kind)
      KIND_DRAW: begin
        if (m_phase != PH_IDLE) o.status = ST_BUSY;
        else if (!map_xy(r.x, r.y, bx, by)) o.status = ST_RANGE;
        else begin
          m_pix[by][bx] = r.color;
          if (!m_dirty[by]) begin
            m_dirty[by] = 1'b1;
            m_dirty_total = (m_dirty_total + 1) & 8'hff;
          end
        end
      end
      KIND_READ: begin
        if (!map_xy(r.x, r.y, bx, by)) o.status = ST_RANGE;
        else o.pixel = m_pix[by][bx];
      end
      KIND_CLEAR: begin
        if (m_phase != PH_IDLE) o.status = ST_BUSY;
        else begin
          for (int i = 0; i < H; i++) begin
            m_pix[i] = '1;
            m_dirty[i] = 1'b1;
          end
          m_dirty_total = H;
        end
      end
      default: begin
        vb = m_vcom ? m_vmask : 8'h00;
        o.select_active = 1'b1;
        case (m_phase)
          PH_IDLE: begin
            if (m_dirty_total == 0) begin
              o.spi_byte = vb;
              m_phase = PH_KEEPALIVE;
            end else begin
              o.spi_byte = vb | m_wcmd;
              seek_line(0);
            end
            m_vcom = ~m_vcom;
          end
          PH_KEEPALIVE: begin
            o.frame_last = 1'b1;
            m_phase = PH_IDLE;
          end
          PH_ADDR: begin
            o.spi_byte = 8'(m_line + 1);
            m_byte = 0;
            m_phase = PH_DATA;
          end
          PH_DATA: begin
            o.spi_byte = m_pix[m_line][m_byte*8 +: 8];
            m_byte++;
            if (m_byte >= LB) begin
              m_byte = 0;
              m_phase = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            if (m_dirty[m_line]) begin
              m_dirty[m_line] = 1'b0;
              if (m_dirty_total > 0) m_dirty_total--;
            end
            seek_line(m_line + 1);
          end
          default: begin
            o.frame_last = 1'b1;
            m_dirty_total = 0;
            m_phase = PH_IDLE;
            m_line = 0;
            m_byte = 0;
          end
        endcase
      end
    endcase
    return o;
  endfunction

  // Driver: bursts of requests with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_DRAW;
    in_ch.x = '0;
    in_ch.y = '0;
    in_ch.color = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_result(
          lcd_request_t'{in_ch.kind, in_ch.x, in_ch.y, in_ch.color}));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          lcd_request_t r;
          r = pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= r.kind;
          in_ch.x <= r.x;
          in_ch.y <= r.y;
          in_ch.color <= r.color;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern on ready.
  logic [15:0] stall_pattern;
  int stall_pos = 0;
  initial begin
    out_ch.ready = 1'b0;
    stall_pattern = 16'hffff;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        lcd_result_t got, want;
        got = '{out_ch.pixel, out_ch.spi_byte, out_ch.select_active,
                out_ch.frame_last, out_ch.status};
        results_seen++;
        if (got.select_active) pulls_seen++;
        if (got.frame_last) frames_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (stall_pos == 15) begin
        stall_pos <= 0;
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hffff;
          1: stall_pattern <= 16'(($urandom & $urandom) | 16'h0001);
          default: stall_pattern <= 16'($urandom);
        endcase
      end else begin
        stall_pos <= stall_pos + 1;
      end
      out_ch.ready <= stall_pattern[stall_pos];
    end
  end

  task automatic add_request(input kind_t k, input int x, input int y, input bit c);
    pending_requests.push_back(lcd_request_t'{k, 16'(x), 16'(y), c});
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROTATION:      m_rot = val[1:0];
      REG_WRITE_COMMAND: m_wcmd = val;
      REG_VCOM_MASK:     m_vmask = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (W * H / 8 + 20) @(posedge clk);
  endtask

  // Random mix of draws, reads and rare clears; pulls only when asked for.
  task automatic add_random_phase(input int count, input bit with_pulls);
    int k;
    for (int i = 0; i < count; i++) begin
      k = with_pulls ? $urandom_range(0, 99) : $urandom_range(0, 50);
      if (k < 30) begin
        // Mostly in-range coordinates, sometimes the full 16-bit span.
        if ($urandom_range(0, 4) == 0)
          add_request(KIND_DRAW, $urandom, $urandom, $urandom);
        else
          add_request(KIND_DRAW, $urandom_range(0, W + 2) - 1,
                      $urandom_range(0, H + 2) - 1, $urandom);
      end else if (k < 50) begin
        if ($urandom_range(0, 4) == 0)
          add_request(KIND_READ, $urandom, $urandom, $urandom);
        else
          add_request(KIND_READ, $urandom_range(0, W + 2) - 1,
                      $urandom_range(0, H + 2) - 1, $urandom);
      end else if (k < 51) begin
        add_request(KIND_CLEAR, $urandom, $urandom, $urandom);
      end else begin
        add_request(KIND_PULL, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < H; i++) begin
      m_pix[i] = '1;
      m_dirty[i] = 1'b1;
    end
    m_dirty_total = H;
    m_vcom = 1'b1;
    m_phase = PH_IDLE;
    m_line = 0;
    m_byte = 0;
    m_rot = 2'd0;
    m_wcmd = 8'h01;
    m_vmask = 8'h02;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_ROTATION, 8'd0);
    write_reg(REG_WRITE_COMMAND, 8'h01);
    write_reg(REG_VCOM_MASK, 8'h02);

    // Directed part: extremes of the coordinates, both colors.
    add_request(KIND_DRAW, 0, 0, 1'b0);
    add_request(KIND_DRAW, W - 1, H - 1, 1'b0);
    add_request(KIND_DRAW, -32768, 32767, 1'b1);
    add_request(KIND_DRAW, W, 0, 1'b0);
    add_request(KIND_DRAW, 0, -1, 1'b0);
    add_request(KIND_READ, 0, 0, 1'b1);
    add_request(KIND_READ, W - 1, H - 1, 1'b0);
    add_request(KIND_READ, 1, 1, 1'b0);
    add_request(KIND_READ, 32767, -32768, 1'b0);
    wait_drained();

    // Random phases across register settings, extremes included, while idle.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin write_reg(REG_ROTATION, 8'd1); write_reg(REG_WRITE_COMMAND, 8'h00);
                 write_reg(REG_VCOM_MASK, 8'hff); end
        1: begin write_reg(REG_ROTATION, 8'd2); write_reg(REG_WRITE_COMMAND, 8'hff);
                 write_reg(REG_VCOM_MASK, 8'h00); end
        2: write_reg(REG_ROTATION, 8'd3);
        default: begin
          write_reg(REG_ROTATION, 8'($urandom_range(0, 3)));
          write_reg(REG_WRITE_COMMAND, 8'($urandom));
          write_reg(REG_VCOM_MASK, 8'($urandom));
        end
      endcase
      add_random_phase(110, 1'b0);
      wait_drained();
    end

    // Open a frame: draw and clear are refused while it runs; reads still work.
    add_request(KIND_PULL, 0, 0, 1'b0);
    add_request(KIND_DRAW, 3, 3, 1'b0);
    add_request(KIND_CLEAR, 0, 0, 1'b0);
    add_request(KIND_READ, 0, 0, 1'b0);
    add_random_phase(160, 1'b1);
    wait_drained();

    $display("Checked %0d results: %0d refresh bytes across %0d frames.",
             results_seen, pulls_seen, frames_seen);
    $display("Exercised every rotation, mask extremes, clears and a busy open frame.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout after %0d results", results_seen);
    $display("Verification failed");
    $finish;
  end
endmodule
